@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/mste_pkg.sv @@
// ---------------------------------------------------------------------------
// mste_pkg
// Commands, sequencer states, beat layout and count-bank write request.
// ---------------------------------------------------------------------------
package mste_pkg;

	// Field widths of one command beat and one result beat
	localparam int CMD_W       = 2;
	localparam int STK_W       = 4;
	localparam int VAL_W       = 8;
	localparam int MCNT_W      = 7;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 2'd0,
		CMD_MOVE = 2'd1,
		CMD_POP  = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_SRC,
		ST_RD_DST,
		ST_EXEC,
		ST_POP_WAIT,
		ST_MV_WR,
		ST_WB
	} state_t;

	// Write request to the fill-count bank
	typedef struct packed {
		logic             wr_src;
		logic             wr_dst;
		logic [STK_W-1:0] src;
		logic [STK_W-1:0] dst;
	} cnt_wr_t;

endpackage

@@ sv/mste_ram.sv @@
// ---------------------------------------------------------------------------
// mste_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module mste_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 576
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read one entry per cycle, and write it when we is set
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ sv/mste_counts.sv @@
// ---------------------------------------------------------------------------
// mste_counts
// Fill-count bank: one count per stack, one read port, two write ports.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mste_counts #(
	parameter int NUM_STACKS  = 9,
	parameter int STACK_DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [mste_pkg::STK_W-1:0]       rd_idx,
	output logic [$clog2(STACK_DEPTH+1)-1:0] rd_cnt,
	input  mste_pkg::cnt_wr_t                wr,
	input  logic [$clog2(STACK_DEPTH+1)-1:0] wr_src_cnt,
	input  logic [$clog2(STACK_DEPTH+1)-1:0] wr_dst_cnt
);
	import mste_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(NUM_STACKS);

	logic [CNT_W-1:0] cnt_q [NUM_STACKS];
	logic             rd_ok;

	// Stacks past the bank read as empty
	assign rd_ok  = {1'b0, rd_idx} < (STK_W + 1)'(NUM_STACKS);
	assign rd_cnt = rd_ok ? cnt_q[rd_idx[IDX_W-1:0]] : '0;

	// Update each count; source write wins
	for (genvar g = 0; g < NUM_STACKS; g++) begin : g_cnt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[g] <= '0;
			end else if (wr.wr_src && wr.src == STK_W'(g)) begin
				cnt_q[g] <= wr_src_cnt;
			end else if (wr.wr_dst && wr.dst == STK_W'(g)) begin
				cnt_q[g] <= wr_dst_cnt;
			end
		end
	end

	`ASSERT_IMPLIES(a_src_cnt_range, wr.wr_src, wr_src_cnt <= CNT_W'(STACK_DEPTH), "source count above depth")
	`ASSERT_IMPLIES(a_dst_cnt_range, wr.wr_dst, wr_dst_cnt <= CNT_W'(STACK_DEPTH), "destination count above depth")
	`ASSERT_IMPLIES(a_dst_not_src, wr.wr_src && wr.wr_dst, wr.src != wr.dst, "double write to one count")

endmodule

@@ sv/multi_stack_transfer_engine_top.sv @@
// Sequence: an accepted command passes RD_SRC, RD_DST and EXEC, then WB loads the result
// beat once the output register is free; pop of a non-empty stack adds POP_WAIT, and a
// move repeats EXEC and MV_WR per item transferred (EXEC alone when source is destination).
// One command at a time: the next is taken only once the result is loaded; each transfer
// uses the single stack memory port twice (read top, then write destination).
// Reset: arst_n clears all fill counts and control at once; no clearing pass,
// stack memory contents are not reset. s_tready is high whenever the sequencer is idle.
// ---------------------------------------------------------------------------
// multi_stack_transfer_engine_top
// Bank of byte stacks with push, pop and item-by-item move under a sequencer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_stack_transfer_engine_top #(
	parameter int NUM_STACKS  = 9,
	parameter int STACK_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// cmd[1:0], first_stack[5:2], second_stack[9:6], push_value[17:10],
	// move_count[24:18], zero fill above
	input  logic [mste_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// pop_value[7:0], was_empty[8], was_full[9], moved_items[16:10], zero fill above
	output logic [mste_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import mste_pkg::*;

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W  = $clog2(NUM_STACKS);
	localparam int ADDR_W = $clog2(NUM_STACKS * STACK_DEPTH);
	localparam int PAD_W  = OUT_TDATA_W - (VAL_W + 2 + MCNT_W);

	state_t state_q, state_d;

	// Latched command
	cmd_t              cmd_q;
	logic [STK_W-1:0]  src_q, dst_q;
	logic [VAL_W-1:0]  val_q;
	logic [MCNT_W-1:0] cnt_q, moved_q;

	// Working counts and addresses
	logic [CNT_W-1:0]  src_cnt_q, dst_cnt_q, rd_cnt;
	logic              src_ok_q, dst_ok_q, same_q;
	logic [ADDR_W-1:0] src_base_q, dst_base_q;

	// Result
	logic [VAL_W-1:0]  pop_q;
	logic              empty_q, full_q;
	logic              m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// Shared memory port and count bank
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [VAL_W-1:0]  ram_wdata, ram_rdata;
	logic [STK_W-1:0]  cnt_rd_idx;
	cnt_wr_t           cnt_wr;

	logic src_has, dst_room, out_free, rd_ok;

	assign src_has  = src_ok_q && src_cnt_q != '0;
	assign dst_room = dst_ok_q && dst_cnt_q < CNT_W'(STACK_DEPTH);
	assign out_free = !m_tvalid_q || m_tready;
	assign rd_ok    = {1'b0, cnt_rd_idx} < (STK_W + 1)'(NUM_STACKS);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	mste_ram #(
		.WIDTH (VAL_W),
		.DEPTH (NUM_STACKS * STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	mste_counts #(
		.NUM_STACKS  (NUM_STACKS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_counts (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_idx     (cnt_rd_idx),
		.rd_cnt     (rd_cnt),
		.wr         (cnt_wr),
		.wr_src_cnt (src_cnt_q),
		.wr_dst_cnt (dst_cnt_q)
	);

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory port and count bank control
	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_addr   = src_base_q + ADDR_W'(src_cnt_q - CNT_W'(1));
		ram_wdata  = val_q;
		cnt_rd_idx = (state_q == ST_RD_DST) ? dst_q : src_q;
		cnt_wr     = '{wr_src: 1'b0, wr_dst: 1'b0, src: src_q, dst: dst_q};
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_RD_SRC;
				end
			end
			ST_RD_SRC: state_d = ST_RD_DST;
			ST_RD_DST: state_d = ST_EXEC;
			ST_EXEC: begin
				case (cmd_q)
					CMD_PUSH: begin
						ram_addr  = src_base_q + ADDR_W'(src_cnt_q);
						ram_we    = src_ok_q && src_cnt_q < CNT_W'(STACK_DEPTH);
						state_d   = ST_WB;
					end
					CMD_POP: begin
						state_d = src_has ? ST_POP_WAIT : ST_WB;
					end
					CMD_MOVE: begin
						if (moved_q == cnt_q || !src_has) begin
							state_d = ST_WB;
						end else if (same_q) begin
							state_d = ST_EXEC;
						end else if (!dst_room) begin
							state_d = ST_WB;
						end else begin
							state_d = ST_MV_WR;
						end
					end
					default: state_d = ST_WB;
				endcase
			end
			ST_POP_WAIT: state_d = ST_WB;
			ST_MV_WR: begin
				ram_we    = 1'b1;
				ram_addr  = dst_base_q + ADDR_W'(dst_cnt_q);
				ram_wdata = ram_rdata;
				state_d   = ST_EXEC;
			end
			ST_WB: begin
				if (out_free) begin
					cnt_wr.wr_src = src_ok_q;
					cnt_wr.wr_dst = (cmd_q == CMD_MOVE) && dst_ok_q && !same_q;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= CMD_NOP;
			cnt_q     <= '0;
			moved_q   <= '0;
			src_cnt_q <= '0;
			dst_cnt_q <= '0;
			src_ok_q  <= 1'b0;
			dst_ok_q  <= 1'b0;
			same_q    <= 1'b0;
			empty_q   <= 1'b0;
			full_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= cmd_t'(s_tdata[1:0]);
						cnt_q   <= s_tdata[24:18];
						moved_q <= '0;
						empty_q <= 1'b0;
						full_q  <= 1'b0;
					end
				end
				ST_RD_SRC: begin
					src_cnt_q <= rd_cnt;
					src_ok_q  <= rd_ok;
				end
				ST_RD_DST: begin
					dst_cnt_q <= rd_cnt;
					dst_ok_q  <= rd_ok;
					same_q    <= (src_q == dst_q);
				end
				ST_EXEC: begin
					case (cmd_q)
						CMD_PUSH: begin
							if (src_ok_q && src_cnt_q < CNT_W'(STACK_DEPTH)) begin
								src_cnt_q <= src_cnt_q + CNT_W'(1);
							end else begin
								full_q <= 1'b1;
							end
						end
						CMD_POP: begin
							if (src_has) begin
								src_cnt_q <= src_cnt_q - CNT_W'(1);
							end else begin
								empty_q <= 1'b1;
							end
						end
						CMD_MOVE: begin
							if (moved_q != cnt_q) begin
								if (!src_has) begin
									empty_q <= 1'b1;
								end else if (same_q) begin
									moved_q <= moved_q + MCNT_W'(1);
								end else if (!dst_room) begin
									full_q <= 1'b1;
								end else begin
									src_cnt_q <= src_cnt_q - CNT_W'(1);
								end
							end
						end
						default: ;
					endcase
				end
				ST_MV_WR: begin
					dst_cnt_q <= dst_cnt_q + CNT_W'(1);
					moved_q   <= moved_q + MCNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	// Payload: operands, base addresses and popped byte
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					src_q <= s_tdata[5:2];
					dst_q <= s_tdata[9:6];
					val_q <= s_tdata[17:10];
					pop_q <= '0;
				end
			end
			ST_RD_SRC: src_base_q <= ADDR_W'(src_q[IDX_W-1:0]) * ADDR_W'(STACK_DEPTH);
			ST_RD_DST: dst_base_q <= ADDR_W'(dst_q[IDX_W-1:0]) * ADDR_W'(STACK_DEPTH);
			ST_POP_WAIT: pop_q <= ram_rdata;
			default: ;
		endcase
	end

	// Output register: load result, drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_WB && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WB && out_free) begin
			m_tdata_q <= {{PAD_W{1'b0}}, moved_q, full_q, empty_q, pop_q};
		end
	end

	`ASSERT_ALWAYS(a_flags_excl, !(m_tvalid_q && m_tdata_q[8] && m_tdata_q[9]), "empty and full both set")
	`ASSERT_ALWAYS(a_moved_bound, moved_q <= cnt_q, "moved past requested count")
	`ASSERT_ALWAYS(a_src_depth, src_cnt_q <= CNT_W'(STACK_DEPTH), "source count above depth")
	`ASSERT_NEXT(a_accept_seq, s_tvalid && s_tready, state_q == ST_RD_SRC, "accept did not start sequence")
	`ASSERT_IMPLIES(a_wr_room, ram_we && state_q == ST_MV_WR, dst_cnt_q < CNT_W'(STACK_DEPTH), "move write to full stack")

endmodule
